// ----- hdl/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// RTD conversion package
// Shared widths, codes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int TEMP_W     = 19;
  localparam int RES_W      = 24;
  localparam int STAT_W     = 3;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COEF_W     = 32;

  localparam int DEF_POS_POINTS       = 32;
  localparam int DEF_NEG_POINTS       = 16;
  localparam int DEF_POS_STEP_DEGREES = 32;
  localparam int DEF_NEG_STEP_DEGREES = 16;

  localparam int MUL_A_W    = 49;
  localparam int MUL_B_W    = 25;
  localparam int ACC_W      = 64;
  localparam int DIV_W      = 42;
  localparam int DIV_CNT_W  = 6;
  localparam int HUNDRED_Q8 = 25600;

  localparam logic [RES_W-1:0]         BASE_RST = 24'd102400;
  localparam logic signed [COEF_W-1:0] A_RST    = 32'sd16785957;
  localparam logic signed [COEF_W-1:0] B_RST    = -32'sd162551799;
  localparam logic signed [COEF_W-1:0] C_RST    = -32'sd77162731;
  localparam logic signed [TEMP_W-1:0] SAT_RST  = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd262144;

  typedef enum logic [OP_W-1:0] {
    OP_R_FROM_T = 2'd0,
    OP_LOAD     = 2'd1,
    OP_T_FROM_R = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK    = 3'd0,
    STS_ABOVE = 3'd1,
    STS_BELOW = 3'd2,
    STS_FLAT  = 3'd3,
    STS_RANGE = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 3'd0,
    CFG_A     = 3'd1,
    CFG_B     = 3'd2,
    CFG_C     = 3'd3,
    CFG_SAT   = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    DP_NONE, DP_LATCH, DP_A, DP_B1, DP_B2, DP_B3, DP_C1, DP_C2, DP_C3, DP_C4,
    DP_R0, DP_R1, DP_R2, DP_LOAD, DP_BADOP, DP_S_ISSUE, DP_S_CMP, DP_S_LO,
    DP_SAT, DP_FLAT, DP_DIV_INIT, DP_DIV, DP_T_FIN
  } dp_cmd_e;

  typedef enum logic [4:0] {
    CS_IDLE, CS_DISP, CS_A, CS_B1, CS_B2, CS_B3, CS_C1, CS_C2, CS_C3, CS_C4,
    CS_R0, CS_R1, CS_R2, CS_LOAD, CS_BAD, CS_S_ISSUE, CS_S_CMP, CS_S_LO,
    CS_DIV_INIT, CS_DIV, CS_T_FIN
  } ctrl_state_e;

  typedef struct packed {
    op_e  op;
    logic t_neg;
    logic at_end;
    logic go;
    logic d_zero;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- hdl/rtc_if.sv -----
// ----------------------------------------------------------------------------
// RTD conversion channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtc_in_if;
  import rtc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [TEMP_W-1:0] temperature_in;
  logic [RES_W-1:0]         resistance_in;
  logic                     table_side;
  logic [IDX_W-1:0]         table_index;
  modport source (output valid, operation, temperature_in, resistance_in, table_side,
                  table_index, input ready);
  modport sink (input valid, operation, temperature_in, resistance_in, table_side,
                table_index, output ready);
endinterface

interface rtc_out_if;
  import rtc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_out;
  logic [RES_W-1:0]         resistance_out;
  logic [STAT_W-1:0]        status;
  modport source (output valid, temperature_out, resistance_out, status, input ready);
  modport sink (input valid, temperature_out, resistance_out, status, output ready);
endinterface

// ----- hdl/rtc_datapath.sv -----
// ----------------------------------------------------------------------------
// RTD conversion datapath
// Configuration registers, grid tables, shared multiplier, divider, result.
// ----------------------------------------------------------------------------
module rtc_datapath #(
  parameter int POS_POINTS       = rtc_pkg::DEF_POS_POINTS,
  parameter int NEG_POINTS       = rtc_pkg::DEF_NEG_POINTS,
  parameter int POS_STEP_DEGREES = rtc_pkg::DEF_POS_STEP_DEGREES,
  parameter int NEG_STEP_DEGREES = rtc_pkg::DEF_NEG_STEP_DEGREES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rtc_pkg::dp_cmd_e                   cmd_i,
  output rtc_pkg::dp_sts_t                   sts_o,
  input  logic                               cfg_we_i,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rtc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [rtc_pkg::OP_W-1:0]           operation_i,
  input  logic signed [rtc_pkg::TEMP_W-1:0]  temperature_in_i,
  input  logic [rtc_pkg::RES_W-1:0]          resistance_in_i,
  input  logic                               table_side_i,
  input  logic [rtc_pkg::IDX_W-1:0]          table_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rtc_pkg::TEMP_W-1:0]  temperature_out_o,
  output logic [rtc_pkg::RES_W-1:0]          resistance_out_o,
  output logic [rtc_pkg::STAT_W-1:0]         status_o
);
  import rtc_pkg::*;

  localparam int PAW   = (POS_POINTS + 1 > 1) ? $clog2(POS_POINTS + 1) : 1;
  localparam int NAW   = (NEG_POINTS + 1 > 1) ? $clog2(NEG_POINTS + 1) : 1;
  localparam int MAXP  = (POS_POINTS > NEG_POINTS) ? POS_POINTS : NEG_POINTS;
  localparam int KW    = $clog2(MAXP + 1);
  localparam int PSTEP = POS_STEP_DEGREES * 256;
  localparam int NSTEP = NEG_STEP_DEGREES * 256;

  logic [RES_W-1:0]         base_q;
  logic signed [COEF_W-1:0] ca_q, cb_q, cc_q;
  logic signed [TEMP_W-1:0] sat_q;

  op_e                      op_q;
  logic signed [TEMP_W-1:0] t_q;
  logic [RES_W-1:0]         res_q;
  logic                     side_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     neg_q;
  logic [KW-1:0]            k_q;
  logic [RES_W-1:0]         hi_ent_q;
  logic signed [ACC_W-1:0]  prod_q, f_q, x_q;
  logic [RES_W-1:0]         den_q;
  logic                     dneg_q, nneg_q;
  logic [DIV_W-1:0]         num_q;
  logic [RES_W-1:0]         rem_q;
  logic [DIV_CNT_W-1:0]     cnt_q;

  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] tout_q;
  logic [RES_W-1:0]         rout_q;
  status_e                  st_q;

  logic [RES_W-1:0] pos_mem [POS_POINTS+1];
  logic [RES_W-1:0] neg_mem [NEG_POINTS+1];
  logic [RES_W-1:0] pos_rd_q, neg_rd_q;

  logic                      pos_we, neg_we, load_ok, fin;
  logic [KW-1:0]             rd_k;
  logic [RES_W-1:0]          rd;
  logic signed [RES_W:0]     dsum, diff_res;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b, step_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
  logic                      mul_en;
  logic signed [ACC_W-1:0]   r_full, absn, q_full, qs, t_full;
  logic [RES_W:0]            rem_sh;

  assign load_ok = side_q ? (int'(idx_q) <= NEG_POINTS) : (int'(idx_q) <= POS_POINTS);
  assign pos_we  = (cmd_i == DP_LOAD) && !side_q && load_ok;
  assign neg_we  = (cmd_i == DP_LOAD) && side_q && load_ok;
  assign rd_k    = (cmd_i == DP_S_ISSUE) ? k_q + 1'b1 : k_q;
  assign rd      = neg_q ? neg_rd_q : pos_rd_q;
  assign dsum    = $signed({1'b0, hi_ent_q}) - $signed({1'b0, rd});
  assign diff_res = $signed({1'b0, res_q}) - $signed({1'b0, rd});
  assign step_b  = neg_q ? MUL_B_W'(NSTEP) : MUL_B_W'(PSTEP);
  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign fin     = (cmd_i == DP_R2) || (cmd_i == DP_LOAD) || (cmd_i == DP_BADOP) ||
                   (cmd_i == DP_SAT) || (cmd_i == DP_FLAT) || (cmd_i == DP_T_FIN);

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[PAW'(idx_q)] <= res_q;
    end
    if (neg_we) begin
      neg_mem[NAW'(idx_q)] <= res_q;
    end
    pos_rd_q <= pos_mem[PAW'(rd_k)];
    neg_rd_q <= neg_mem[NAW'(rd_k)];
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i)
      DP_A: begin
        mul_a = MUL_A_W'(ca_q);
        mul_b = MUL_B_W'(t_q);
      end
      DP_B1: begin
        mul_a = MUL_A_W'(cb_q);
        mul_b = MUL_B_W'(t_q);
      end
      DP_B2: begin
        mul_a = MUL_A_W'(prod_q >>> 6);
        mul_b = MUL_B_W'(t_q);
      end
      DP_B3: begin
        mul_a = MUL_A_W'(cc_q);
        mul_b = MUL_B_W'(t_q);
      end
      DP_C1, DP_C2: begin
        mul_a = MUL_A_W'(prod_q >>> 16);
        mul_b = MUL_B_W'(t_q);
      end
      DP_C3: begin
        mul_a = MUL_A_W'(prod_q >>> 8);
        mul_b = MUL_B_W'(t_q) - MUL_B_W'(HUNDRED_Q8);
      end
      DP_R0: begin
        mul_a = $signed({{(MUL_A_W-20){1'b0}}, f_q[19:0]});
        mul_b = $signed({1'b0, base_q});
      end
      DP_R1: begin
        mul_a = MUL_A_W'(f_q >>> 20);
        mul_b = $signed({1'b0, base_q});
      end
      DP_S_LO: begin
        mul_a = MUL_A_W'(diff_res);
        mul_b = step_b;
      end
      DP_DIV_INIT: begin
        mul_a = $signed({{(MUL_A_W-KW){1'b0}}, k_q});
        mul_b = step_b;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign r_full = (prod_q + (x_q >>> 20)) >>> 20;
  assign absn   = prod_q[ACC_W-1] ? -prod_q : prod_q;
  assign q_full = $signed({{(ACC_W-DIV_W){1'b0}}, num_q});
  assign qs     = (nneg_q ^ dneg_q) ? -q_full : q_full;
  assign t_full = neg_q ? (-prod_q - qs) : (prod_q + qs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RST;
      ca_q   <= A_RST;
      cb_q   <= B_RST;
      cc_q   <= C_RST;
      sat_q  <= SAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE: base_q <= cfg_data_i[RES_W-1:0];
        CFG_A:    ca_q   <= $signed(cfg_data_i);
        CFG_B:    cb_q   <= $signed(cfg_data_i);
        CFG_C:    cc_q   <= $signed(cfg_data_i);
        CFG_SAT:  sat_q  <= $signed(cfg_data_i[TEMP_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end
      if (cmd_i == DP_DIV_INIT) begin
        cnt_q <= '0;
      end else if (cmd_i == DP_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= ACC_W'(mul_p);
    end
    case (cmd_i)
      DP_LATCH: begin
        op_q   <= op_e'(operation_i);
        t_q    <= temperature_in_i;
        res_q  <= resistance_in_i;
        side_q <= table_side_i;
        idx_q  <= table_index_i;
        neg_q  <= resistance_in_i < base_q;
        k_q    <= '0;
      end
      DP_B1: f_q <= (ACC_W'(1) <<< 40) + prod_q;
      DP_B3: f_q <= f_q + (prod_q >>> 18);
      DP_C4: f_q <= f_q + (prod_q >>> 16);
      DP_R1: x_q <= prod_q + (ACC_W'(1) <<< 39);
      DP_R2: begin
        tout_q <= '0;
        if (r_full < 0) begin
          rout_q <= '0;
          st_q   <= STS_RANGE;
        end else if (r_full > ACC_W'({RES_W{1'b1}})) begin
          rout_q <= '1;
          st_q   <= STS_RANGE;
        end else begin
          rout_q <= r_full[RES_W-1:0];
          st_q   <= STS_OK;
        end
      end
      DP_LOAD: begin
        tout_q <= '0;
        rout_q <= '0;
        st_q   <= load_ok ? STS_OK : STS_RANGE;
      end
      DP_BADOP: begin
        tout_q <= '0;
        rout_q <= '0;
        st_q   <= STS_RANGE;
      end
      DP_S_CMP: begin
        if (sts_o.go) begin
          k_q <= k_q + 1'b1;
        end else begin
          hi_ent_q <= rd;
        end
      end
      DP_S_LO: begin
        den_q  <= dsum[RES_W] ? RES_W'(-dsum) : RES_W'(dsum);
        dneg_q <= dsum[RES_W];
      end
      DP_SAT: begin
        tout_q <= sat_q;
        rout_q <= '0;
        st_q   <= neg_q ? STS_BELOW : STS_ABOVE;
      end
      DP_FLAT: begin
        tout_q <= sat_q;
        rout_q <= '0;
        st_q   <= STS_FLAT;
      end
      DP_DIV_INIT: begin
        nneg_q <= prod_q[ACC_W-1];
        num_q  <= DIV_W'(absn + ACC_W'(den_q >> 1));
        rem_q  <= '0;
      end
      DP_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= RES_W'(rem_sh - {1'b0, den_q});
          num_q <= {num_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[RES_W-1:0];
          num_q <= {num_q[DIV_W-2:0], 1'b0};
        end
      end
      DP_T_FIN: begin
        rout_q <= '0;
        if (t_full > ACC_W'(TEMP_MAX)) begin
          tout_q <= TEMP_MAX;
          st_q   <= STS_RANGE;
        end else if (t_full < ACC_W'(TEMP_MIN)) begin
          tout_q <= TEMP_MIN;
          st_q   <= STS_RANGE;
        end else begin
          tout_q <= t_full[TEMP_W-1:0];
          st_q   <= STS_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.t_neg    = t_q[TEMP_W-1];
    sts_o.at_end   = neg_q ? (k_q == KW'(NEG_POINTS)) : (k_q == KW'(POS_POINTS));
    sts_o.go       = neg_q ? (res_q < rd) : (res_q > rd);
    sts_o.d_zero   = (hi_ent_q == rd);
    sts_o.div_done = (cnt_q == DIV_CNT_W'(DIV_W));
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign temperature_out_o = tout_q;
  assign resistance_out_o  = rout_q;
  assign status_o          = st_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !(out_valid_q && !out_ready_i))
    else $error("Pending result overwritten.");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (st_q <= STS_RANGE))
    else $error("Result carries an undefined status.");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIV_CNT_W'(DIV_W))
    else $error("Divider ran past its last step.");
endmodule

// ----- hdl/rtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// RTD conversion controller
// Sequences the datapath through each operation, one transaction at a time.
// ----------------------------------------------------------------------------
module rtc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rtc_pkg::dp_sts_t  sts_i,
  output rtc_pkg::dp_cmd_e  cmd_o
);
  import rtc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = DP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = DP_LATCH;
          state_d = CS_DISP;
        end
      end
      CS_DISP: begin
        case (sts_i.op)
          OP_R_FROM_T: state_d = CS_A;
          OP_LOAD:     state_d = CS_LOAD;
          OP_T_FROM_R: state_d = CS_S_ISSUE;
          default:     state_d = CS_BAD;
        endcase
      end
      CS_A: begin
        cmd_o   = DP_A;
        state_d = CS_B1;
      end
      CS_B1: begin
        cmd_o   = DP_B1;
        state_d = CS_B2;
      end
      CS_B2: begin
        cmd_o   = DP_B2;
        state_d = CS_B3;
      end
      CS_B3: begin
        cmd_o   = DP_B3;
        state_d = sts_i.t_neg ? CS_C1 : CS_R0;
      end
      CS_C1: begin
        cmd_o   = DP_C1;
        state_d = CS_C2;
      end
      CS_C2: begin
        cmd_o   = DP_C2;
        state_d = CS_C3;
      end
      CS_C3: begin
        cmd_o   = DP_C3;
        state_d = CS_C4;
      end
      CS_C4: begin
        cmd_o   = DP_C4;
        state_d = CS_R0;
      end
      CS_R0: begin
        cmd_o   = DP_R0;
        state_d = CS_R1;
      end
      CS_R1: begin
        cmd_o   = DP_R1;
        state_d = CS_R2;
      end
      CS_R2: begin
        if (!sts_i.out_busy) begin
          cmd_o   = DP_R2;
          state_d = CS_IDLE;
        end
      end
      CS_LOAD: begin
        if (!sts_i.out_busy) begin
          cmd_o   = DP_LOAD;
          state_d = CS_IDLE;
        end
      end
      CS_BAD: begin
        if (!sts_i.out_busy) begin
          cmd_o   = DP_BADOP;
          state_d = CS_IDLE;
        end
      end
      CS_S_ISSUE: begin
        if (sts_i.at_end) begin
          if (!sts_i.out_busy) begin
            cmd_o   = DP_SAT;
            state_d = CS_IDLE;
          end
        end else begin
          cmd_o   = DP_S_ISSUE;
          state_d = CS_S_CMP;
        end
      end
      CS_S_CMP: begin
        cmd_o   = DP_S_CMP;
        state_d = sts_i.go ? CS_S_ISSUE : CS_S_LO;
      end
      CS_S_LO: begin
        if (sts_i.d_zero) begin
          if (!sts_i.out_busy) begin
            cmd_o   = DP_FLAT;
            state_d = CS_IDLE;
          end
        end else begin
          cmd_o   = DP_S_LO;
          state_d = CS_DIV_INIT;
        end
      end
      CS_DIV_INIT: begin
        cmd_o   = DP_DIV_INIT;
        state_d = CS_DIV;
      end
      CS_DIV: begin
        if (sts_i.div_done) begin
          state_d = CS_T_FIN;
        end else begin
          cmd_o = DP_DIV;
        end
      end
      CS_T_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o   = DP_T_FIN;
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end
endmodule

// ----- hdl/rtd_resistance_temperature_convert.sv -----
// ----------------------------------------------------------------------------
// RTD resistance/temperature converter
// Callendar-Van Dusen resistance from temperature, grid table loading, and
// temperature from resistance by table search and interpolation.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_i    in         operation, temperature_in, resistance_in, table_side,
//                      table_index
//  rsp_o    out        temperature_out, resistance_out, status
//  cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One transaction is worked on at a time through a single shared multiplier.
// Resistance from temperature adds the C1 to C4 steps below 0 C. Temperature
// from resistance finds the segment k by the one-port table search and then
// interpolates through the 42-step divider; a flat segment or a miss beyond
// the table ends without the divider. Reset clears the controller, the
// configuration registers, the output valid flag and the divider count; the
// tables and the working registers hold no reset value. A stalled result
// waits in the output register and the next transaction is already accepted
// and worked on.
// ----------------------------------------------------------------------------
module rtd_resistance_temperature_convert #(
  parameter int POS_POINTS       = rtc_pkg::DEF_POS_POINTS,
  parameter int NEG_POINTS       = rtc_pkg::DEF_NEG_POINTS,
  parameter int POS_STEP_DEGREES = rtc_pkg::DEF_POS_STEP_DEGREES,
  parameter int NEG_STEP_DEGREES = rtc_pkg::DEF_NEG_STEP_DEGREES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rtc_in_if.sink                         req_i,
  rtc_out_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rtc_pkg::*;

  dp_cmd_e cmd;
  dp_sts_t sts;

  rtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtc_datapath #(
    .POS_POINTS       (POS_POINTS),
    .NEG_POINTS       (NEG_POINTS),
    .POS_STEP_DEGREES (POS_STEP_DEGREES),
    .NEG_STEP_DEGREES (NEG_STEP_DEGREES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (req_i.operation),
    .temperature_in_i  (req_i.temperature_in),
    .resistance_in_i   (req_i.resistance_in),
    .table_side_i      (req_i.table_side),
    .table_index_i     (req_i.table_index),
    .out_valid_o       (rsp_o.valid),
    .out_ready_i       (rsp_o.ready),
    .temperature_out_o (rsp_o.temperature_out),
    .resistance_out_o  (rsp_o.resistance_out),
    .status_o          (rsp_o.status)
  );
endmodule
